// ===== src/rdld_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdld_pkg
// Shared types and codes of the optimal string alignment distance engine.
// ----------------------------------------------------------------------------
`default_nettype none

package rdld_pkg;

   localparam int SYMBOL_W = 8;
   localparam int CMD_W    = 2;
   localparam int DIST_W   = 7;

   localparam logic [CMD_W-1:0] CMD_FIRST   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SECOND  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_ROW    = 4'b0010,
      ST_CELL   = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

endpackage

`default_nettype wire

// ===== src/rdld_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdld_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rdld_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // read data holds while rd_en is low
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== src/restricted_damerau_levenshtein_distance.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// restricted_damerau_levenshtein_distance
// Loads two byte strings and computes their optimal string alignment distance.
// ----------------------------------------------------------------------------
//  channel  | direction | tdata                      | tuser
//  req_     | in        | [7:0] symbol               | [1:0] command
//  rsp_     | out       | [6:0] distance, [7] zero   | [0] overflow
//
//  a load word leaves the engine idle; req_tready stays high
//  a compute word with strings of n and m symbols holds req_tready low while
//  the engine works row by row: a ROW step fetches the first-string symbol,
//  then one cell per cycle through the row memory read-modify-write, then FINISH
//  with an empty string the engine skips the rows and goes straight to FINISH
//  reset is synchronous and clears lengths, drop flag and control; a stalled
//  result holds the engine in its last step until rsp_tready
// ----------------------------------------------------------------------------
`default_nettype none

module restricted_damerau_levenshtein_distance #(
   parameter int MAX_LEN = 64
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] symbol
   input  wire logic [1:0] req_tuser,   // [1:0] command
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic      [7:0] rsp_tdata,   // [6:0] distance, [7] zero fill
   output logic            rsp_tuser    // [0] overflow
);

   localparam int CW = $clog2(MAX_LEN + 1);
   localparam int AW = $clog2(MAX_LEN);
   localparam int SW = rdld_pkg::SYMBOL_W;
   localparam int DW = rdld_pkg::DIST_W;
   localparam int RW = SW + 2 * CW;

   rdld_pkg::state_type state_ff, state_in;

   logic [CW-1:0] first_count_ff, first_count_in;
   logic [CW-1:0] second_count_ff, second_count_in;
   logic          dropped_ff, dropped_in;
   logic [CW-1:0] row_ff, row_in;
   logic [CW-1:0] col_ff, col_in;
   logic [SW-1:0] a_prev_ff, a_prev_in;
   logic [SW-1:0] b_prev_ff, b_prev_in;
   logic [CW-1:0] left_ff, left_in;
   logic [CW-1:0] diag_ff, diag_in;
   logic [CW-1:0] tb1_ff, tb1_in;
   logic [CW-1:0] tb2_ff, tb2_in;
   logic [CW-1:0] result_ff, result_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [DW-1:0] rsp_dist_ff, rsp_dist_in;
   logic          rsp_ovf_ff, rsp_ovf_in;

   // text and row memory ports
   logic            a_we, b_we, a_re, b_re, t_re, t_we;
   logic [AW-1:0]   a_waddr, b_waddr, a_raddr, b_raddr, t_raddr, t_waddr;
   logic [SW-1:0]   a_rdata, b_rdata;
   logic [RW-1:0]   t_wdata, t_rdata;

   logic          accept;
   logic [CW-1:0] row_m1, col_m1;
   logic [CW-1:0] one_j, two_j, cur_j;
   logic [CW:0]   sub_cost, del_cost, ins_cost, tr_cost, best;
   logic          trans_ok;

   assign req_tready = (state_ff == rdld_pkg::ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign row_m1     = row_ff - CW'(1);
   assign col_m1     = col_ff - CW'(1);

   rdld_ram #(.WIDTH(SW), .DEPTH(MAX_LEN)) u_first_text (
      .clock  (clock),
      .wr_en  (a_we),
      .wr_addr(a_waddr),
      .wr_data(req_tdata),
      .rd_en  (a_re),
      .rd_addr(a_raddr),
      .rd_data(a_rdata)
   );

   // one word per column: {second-string symbol, two rows back, one row back}
   rdld_ram #(.WIDTH(RW), .DEPTH(MAX_LEN)) u_rows (
      .clock  (clock),
      .wr_en  (t_we),
      .wr_addr(t_waddr),
      .wr_data(t_wdata),
      .rd_en  (t_re),
      .rd_addr(t_raddr),
      .rd_data(t_rdata)
   );

   assign a_we    = accept && (req_tuser == rdld_pkg::CMD_FIRST)
                    && (first_count_ff < CW'(MAX_LEN));
   assign b_we    = accept && (req_tuser == rdld_pkg::CMD_SECOND)
                    && (second_count_ff < CW'(MAX_LEN));
   assign a_waddr = first_count_ff[AW-1:0];
   assign b_waddr = second_count_ff[AW-1:0];

   assign a_re    = (state_ff == rdld_pkg::ST_ROW);
   assign a_raddr = row_m1[AW-1:0];

   // next column is fetched while the current one is worked
   always_comb begin
      if (state_ff == rdld_pkg::ST_ROW) begin
         b_re    = 1'b1;
         b_raddr = '0;
      end else begin
         b_re    = (state_ff == rdld_pkg::ST_CELL) && (col_ff != second_count_ff);
         b_raddr = col_ff[AW-1:0];
      end
   end
   assign t_re    = b_re;
   assign t_raddr = b_raddr;
   assign b_rdata = t_rdata[RW-1:2*CW];

   // cell datapath; the first row starts from the column index
   always_comb begin
      if (row_ff == CW'(1)) begin
         one_j = col_ff;
         two_j = col_ff;
      end else begin
         one_j = t_rdata[CW-1:0];
         two_j = t_rdata[2*CW-1:CW];
      end
      sub_cost = {1'b0, diag_ff} + ((a_rdata == b_rdata) ? (CW+1)'(0) : (CW+1)'(1));
      del_cost = {1'b0, one_j} + (CW+1)'(1);
      ins_cost = {1'b0, left_ff} + (CW+1)'(1);
      tr_cost  = {1'b0, tb2_ff} + (CW+1)'(1);
      trans_ok = (row_ff > CW'(1)) && (col_ff > CW'(1))
                 && (a_rdata == b_prev_ff) && (a_prev_ff == b_rdata);
      best = (del_cost < ins_cost) ? del_cost : ins_cost;
      if (sub_cost < best) begin
         best = sub_cost;
      end
      if (trans_ok && (tr_cost < best)) begin
         best = tr_cost;
      end
      cur_j = best[CW-1:0];
   end

   // second-string loads write the symbol, cells write back the symbol with the new rows
   assign t_we    = b_we || (state_ff == rdld_pkg::ST_CELL);
   assign t_waddr = b_we ? b_waddr : col_m1[AW-1:0];
   assign t_wdata = b_we ? {req_tdata, (2*CW)'(0)} : {b_rdata, one_j, cur_j};

   always_comb begin
      state_in        = state_ff;
      first_count_in  = first_count_ff;
      second_count_in = second_count_ff;
      dropped_in      = dropped_ff;
      row_in          = row_ff;
      col_in          = col_ff;
      a_prev_in       = a_prev_ff;
      b_prev_in       = b_prev_ff;
      left_in         = left_ff;
      diag_in         = diag_ff;
      tb1_in          = tb1_ff;
      tb2_in          = tb2_ff;
      result_in       = result_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_tready;
      rsp_dist_in     = rsp_dist_ff;
      rsp_ovf_in      = rsp_ovf_ff;

      case (state_ff)
         rdld_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_tuser)
                  rdld_pkg::CMD_FIRST: begin
                     if (a_we) begin
                        first_count_in = first_count_ff + CW'(1);
                     end else begin
                        dropped_in = 1'b1;
                     end
                  end
                  rdld_pkg::CMD_SECOND: begin
                     if (b_we) begin
                        second_count_in = second_count_ff + CW'(1);
                     end else begin
                        dropped_in = 1'b1;
                     end
                  end
                  rdld_pkg::CMD_COMPUTE: begin
                     if ((first_count_ff == '0) || (second_count_ff == '0)) begin
                        // one side empty: distance is the other length
                        result_in = first_count_ff | second_count_ff;
                        state_in  = rdld_pkg::ST_FINISH;
                     end else begin
                        row_in   = CW'(1);
                        state_in = rdld_pkg::ST_ROW;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         rdld_pkg::ST_ROW: begin
            col_in   = CW'(1);
            left_in  = row_ff;
            diag_in  = row_m1;
            tb1_in   = row_ff - CW'(2);
            state_in = rdld_pkg::ST_CELL;
         end
         rdld_pkg::ST_CELL: begin
            left_in   = cur_j;
            diag_in   = one_j;
            tb1_in    = two_j;
            tb2_in    = tb1_ff;
            b_prev_in = b_rdata;
            col_in    = col_ff + CW'(1);
            if (col_ff == second_count_ff) begin
               if (row_ff == first_count_ff) begin
                  result_in = cur_j;
                  state_in  = rdld_pkg::ST_FINISH;
               end else begin
                  row_in    = row_ff + CW'(1);
                  a_prev_in = a_rdata;
                  state_in  = rdld_pkg::ST_ROW;
               end
            end
         end
         rdld_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in    = 1'b1;
               rsp_dist_in     = DW'(result_ff);
               rsp_ovf_in      = dropped_ff;
               first_count_in  = '0;
               second_count_in = '0;
               dropped_in      = 1'b0;
               state_in        = rdld_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rdld_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= rdld_pkg::ST_IDLE;
         first_count_ff  <= '0;
         second_count_ff <= '0;
         dropped_ff      <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         first_count_ff  <= first_count_in;
         second_count_ff <= second_count_in;
         dropped_ff      <= dropped_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff      <= row_in;
      col_ff      <= col_in;
      a_prev_ff   <= a_prev_in;
      b_prev_ff   <= b_prev_in;
      left_ff     <= left_in;
      diag_ff     <= diag_in;
      tb1_ff      <= tb1_in;
      tb2_ff      <= tb2_in;
      result_ff   <= result_in;
      rsp_dist_ff <= rsp_dist_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_dist_ff};
   assign rsp_tuser  = rsp_ovf_ff;

endmodule

`default_nettype wire

// ===== src/rdld_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdld_checker
// Port-level checks of the distance engine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rdld_checker #(
   parameter int MAX_LEN = 64
) (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_tvalid,
   input wire logic       req_tready,
   input wire logic [1:0] req_tuser,
   input wire logic       rsp_tvalid,
   input wire logic       rsp_tready,
   input wire logic [7:0] rsp_tdata,
   input wire logic       rsp_tuser
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result word changed while stalled");

   // distance never exceeds MAX_LEN (checked while MAX_LEN fits in 7 bits), fill bit stays zero
   a_rsp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !rsp_tdata[7] && ((MAX_LEN > 127) || (rsp_tdata[6:0] <= 7'(MAX_LEN))))
      else $error("distance out of range");

   // a compute word takes the engine busy on the next cycle
   a_compute_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == rdld_pkg::CMD_COMPUTE) |=> !req_tready)
      else $error("input ready while computing");

   // a load word never produces a result
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser != rdld_pkg::CMD_COMPUTE) && !rsp_tvalid
      |=> !rsp_tvalid)
      else $error("result after a load word");

endmodule

bind restricted_damerau_levenshtein_distance rdld_checker #(.MAX_LEN(MAX_LEN)) u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .req_tuser (req_tuser),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata),
   .rsp_tuser (rsp_tuser)
);

`default_nettype wire

// ===== sim/tb_restricted_damerau_levenshtein_distance.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_restricted_damerau_levenshtein_distance
// Streams string loads and compute commands into the distance engine.
// Results are checked against an in-bench alignment table, with random gaps
// on the request channel and random backpressure on the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_restricted_damerau_levenshtein_distance;

   localparam int MAX_LEN     = 64;
   localparam int CYCLE_LIMIT = 3_000_000;
   localparam logic [rdld_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

   typedef struct packed {
      logic [rdld_pkg::DIST_W-1:0] distance;
      logic                        overflow;
   } osa_result_type;

   typedef enum int {EDIT_SWAP, EDIT_REPLACE, EDIT_DELETE, EDIT_INSERT} edit_kind_type;

   logic       clock;
   logic       reset;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;   // [7:0] symbol
   logic [1:0] req_tuser;   // [1:0] command
   logic       rsp_tvalid;
   logic       rsp_tready;
   logic [7:0] rsp_tdata;   // [6:0] distance, [7] zero fill
   logic       rsp_tuser;   // [0] overflow

   // bench copy of the engine state
   logic [7:0]     first_str [MAX_LEN];
   logic [7:0]     second_str[MAX_LEN];
   int             first_len;
   int             second_len;
   logic           drop_seen;
   osa_result_type pending_distances[$];

   logic [7:0]  pair_first[$];
   logic [7:0]  pair_second[$];

   int   words_sent;
   int   mismatch_count;
   int   cycle_count;
   logic send_idle;
   logic recv_idle;

   restricted_damerau_levenshtein_distance #(.MAX_LEN(MAX_LEN)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("tb_restricted_damerau_levenshtein_distance: done, errors");
         $finish;
      end
   end

   // full alignment table over the loaded prefixes
   function automatic logic [rdld_pkg::DIST_W-1:0] osa_distance();
      int two_back[MAX_LEN+1];
      int one_back[MAX_LEN+1];
      int row_now [MAX_LEN+1];
      int best;
      logic [7:0] a;
      logic [7:0] b;
      for (int j = 0; j <= second_len; j++) begin
         one_back[j] = j;
         two_back[j] = j;
      end
      for (int i = 1; i <= first_len; i++) begin
         a = first_str[i-1];
         row_now[0] = i;
         for (int j = 1; j <= second_len; j++) begin
            b = second_str[j-1];
            best = one_back[j-1] + ((a == b) ? 0 : 1);
            if (one_back[j] + 1 < best) best = one_back[j] + 1;
            if (row_now[j-1] + 1 < best) best = row_now[j-1] + 1;
            if (i > 1 && j > 1 && a == second_str[j-2] && first_str[i-2] == b &&
                two_back[j-2] + 1 < best)
               best = two_back[j-2] + 1;
            row_now[j] = best;
         end
         two_back = one_back;
         one_back = row_now;
      end
      return one_back[second_len][rdld_pkg::DIST_W-1:0];
   endfunction

   function automatic void predict_word(input logic [rdld_pkg::CMD_W-1:0] cmd,
                                        input logic [7:0] sym);
      osa_result_type res;
      case (cmd)
         rdld_pkg::CMD_FIRST: begin
            if (first_len < MAX_LEN) begin
               first_str[first_len] = sym;
               first_len++;
            end else begin
               drop_seen = 1'b1;
            end
         end
         rdld_pkg::CMD_SECOND: begin
            if (second_len < MAX_LEN) begin
               second_str[second_len] = sym;
               second_len++;
            end else begin
               drop_seen = 1'b1;
            end
         end
         rdld_pkg::CMD_COMPUTE: begin
            res.distance = osa_distance();
            res.overflow = drop_seen;
            pending_distances.push_back(res);
            first_len  = 0;
            second_len = 0;
            drop_seen  = 1'b0;
         end
         default: ;
      endcase
   endfunction

   // called at a falling edge; returns at the falling edge after the word is taken
   task automatic send_word(input logic [rdld_pkg::CMD_W-1:0] cmd, input logic [7:0] sym);
      if (send_idle && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= sym;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_word(cmd, sym);
      if (cmd != CMD_UNUSED) words_sent++;
      @(negedge clock);
   endtask

   task automatic stop_sending();
      req_tvalid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      while (pending_distances.size() != 0) @(negedge clock);
   endtask

   function automatic int pick_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) return $urandom_range(0, 10);
      if (r < 95) return $urandom_range(11, 40);
      if (r < 98) return $urandom_range(41, MAX_LEN);
      return $urandom_range(MAX_LEN + 1, MAX_LEN + 6);
   endfunction

   // narrow alphabet most of the time so matches and swaps are common
   function automatic logic [7:0] pick_symbol(input logic [7:0] base);
      if ($urandom_range(0, 2) != 0) return base + 8'($urandom_range(0, 2));
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic send_string(input logic [rdld_pkg::CMD_W-1:0] cmd, input int len);
      logic [7:0] base;
      base = 8'($urandom_range(0, 255));
      repeat (len) send_word(cmd, pick_symbol(base));
   endtask

   task automatic send_pair(input logic noisy);
      int fi;
      int si;
      int pos;
      logic interleave;
      logic [7:0] base;
      logic [7:0] held;
      base = 8'($urandom_range(0, 255));
      pair_first.delete();
      pair_second.delete();
      repeat (pick_length()) pair_first.push_back(pick_symbol(base));
      if ($urandom_range(0, 2) != 0) begin
         // second string is a lightly edited copy of the first
         pair_second = pair_first;
         repeat ($urandom_range(0, 3)) begin
            case (edit_kind_type'($urandom_range(0, 3)))
               EDIT_SWAP: begin
                  if (pair_second.size() >= 2) begin
                     pos = $urandom_range(0, pair_second.size() - 2);
                     held = pair_second[pos];
                     pair_second[pos]   = pair_second[pos+1];
                     pair_second[pos+1] = held;
                  end
               end
               EDIT_REPLACE: begin
                  if (pair_second.size() > 0)
                     pair_second[$urandom_range(0, pair_second.size() - 1)] = pick_symbol(base);
               end
               EDIT_DELETE: begin
                  if (pair_second.size() > 0)
                     pair_second.delete($urandom_range(0, pair_second.size() - 1));
               end
               default: begin
                  pair_second.insert($urandom_range(0, pair_second.size()), pick_symbol(base));
               end
            endcase
         end
      end else begin
         repeat (pick_length()) pair_second.push_back(pick_symbol(base));
      end
      interleave = ($urandom_range(0, 3) == 0);
      fi = 0;
      si = 0;
      while (fi < pair_first.size() || si < pair_second.size()) begin
         if (noisy && $urandom_range(0, 15) == 0)
            send_word(CMD_UNUSED, 8'($urandom_range(0, 255)));
         if (si >= pair_second.size() ||
             (fi < pair_first.size() && (!interleave || $urandom_range(0, 1) == 1))) begin
            send_word(rdld_pkg::CMD_FIRST, pair_first[fi]);
            fi++;
         end else begin
            send_word(rdld_pkg::CMD_SECOND, pair_second[si]);
            si++;
         end
      end
      // now and then no compute, so the strings run into the next pair
      if (!noisy || $urandom_range(0, 19) != 0)
         send_word(rdld_pkg::CMD_COMPUTE, 8'($urandom_range(0, 255)));
      if (noisy && $urandom_range(0, 24) == 0)
         send_word(rdld_pkg::CMD_COMPUTE, 8'($urandom_range(0, 255)));
   endtask

   task automatic test_directed_cases();
      send_word(rdld_pkg::CMD_COMPUTE, 8'h00);           // both empty
      send_word(rdld_pkg::CMD_FIRST,   8'h61);
      send_word(rdld_pkg::CMD_FIRST,   8'h62);
      send_word(rdld_pkg::CMD_COMPUTE, 8'hff);           // second empty
      send_word(rdld_pkg::CMD_SECOND,  8'hff);
      send_word(rdld_pkg::CMD_COMPUTE, 8'h00);           // first empty
      send_word(rdld_pkg::CMD_FIRST,   8'h61);
      send_word(rdld_pkg::CMD_FIRST,   8'h62);
      send_word(rdld_pkg::CMD_SECOND,  8'h62);
      send_word(rdld_pkg::CMD_SECOND,  8'h61);
      send_word(rdld_pkg::CMD_COMPUTE, 8'h00);           // adjacent swap
      send_word(rdld_pkg::CMD_FIRST,   8'h00);
      send_word(rdld_pkg::CMD_FIRST,   8'hff);
      send_word(rdld_pkg::CMD_SECOND,  8'h00);
      send_word(rdld_pkg::CMD_SECOND,  8'hff);
      send_word(rdld_pkg::CMD_COMPUTE, 8'h00);           // identical
      send_word(rdld_pkg::CMD_FIRST,   8'h55);
      send_word(CMD_UNUSED,            8'haa);           // unused command in the middle
      send_word(rdld_pkg::CMD_SECOND,  8'h55);
      send_word(rdld_pkg::CMD_COMPUTE, 8'haa);
   endtask

   task automatic test_full_length();
      send_string(rdld_pkg::CMD_FIRST,  MAX_LEN);
      send_string(rdld_pkg::CMD_SECOND, MAX_LEN);
      send_word(rdld_pkg::CMD_COMPUTE, 8'h00);           // both exactly full, no drop
      send_string(rdld_pkg::CMD_FIRST,  MAX_LEN + 2);
      send_string(rdld_pkg::CMD_SECOND, 3);
      send_word(rdld_pkg::CMD_COMPUTE, 8'h00);           // first string full
      send_string(rdld_pkg::CMD_FIRST,  2);
      send_string(rdld_pkg::CMD_SECOND, MAX_LEN + 1);
      send_word(rdld_pkg::CMD_COMPUTE, 8'h00);           // second string full
      send_word(rdld_pkg::CMD_COMPUTE, 8'h00);           // drop flag cleared
   endtask

   task automatic test_random_pairs(input int word_goal);
      int start;
      start = words_sent;
      while (words_sent - start < word_goal) send_pair(1'b1);
   endtask

   task automatic test_drain_pause();
      repeat (3) begin
         send_pair(1'b0);
         stop_sending();
         wait_drained();
         send_pair(1'b0);
      end
   endtask

   task automatic test_no_idle(input int word_goal);
      send_idle = 1'b0;
      recv_idle = 1'b0;
      test_random_pairs(word_goal);
   endtask

   task automatic report_mismatch(input string what, input logic [7:0] want_data,
                                  input logic want_user);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t: %s: expected tdata %02h tuser %0b, got tdata %02h tuser %0b",
                  $realtime, what, want_data, want_user, rsp_tdata, rsp_tuser);
   endtask

   always @(posedge clock) begin : check_results
      osa_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_distances.size() == 0) begin
            report_mismatch("unexpected result word", 8'h00, 1'b0);
         end else begin
            want = pending_distances.pop_front();
            if (rsp_tdata !== {1'b0, want.distance} || rsp_tuser !== want.overflow)
               report_mismatch("result mismatch", {1'b0, want.distance}, want.overflow);
         end
      end
   end

   initial begin : ready_driver
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (recv_idle && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   initial begin
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      req_tuser      = '0;
      first_len      = 0;
      second_len     = 0;
      drop_seen      = 1'b0;
      words_sent     = 0;
      mismatch_count = 0;
      cycle_count    = 0;
      send_idle      = 1'b1;
      recv_idle      = 1'b1;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed_cases();
      test_full_length();
      test_random_pairs(550);
      test_drain_pause();
      test_random_pairs(500);
      test_no_idle(450);

      stop_sending();
      wait_drained();
      repeat (20) @(negedge clock);
      if (mismatch_count == 0 && pending_distances.size() == 0) begin
         $display("tb_restricted_damerau_levenshtein_distance: done, clean");
      end else begin
         $display("tb_restricted_damerau_levenshtein_distance: done, errors");
      end
      $finish;
   end

endmodule

`default_nettype wire
